/* rtl/crc16_response_frame_receiver_defines.svh */
// Assertion macros for the CRC-16 response frame receiver checker.
// No dependencies; included by the checker file.
`ifndef CRC16_RESPONSE_FRAME_RECEIVER_DEFINES_SVH
`define CRC16_RESPONSE_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CRFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CRFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/crfr_pkg.sv */
// Shared types, constants and the CRC byte update for the frame receiver.
// No dependencies; imported by the top level and the checker.
`default_nettype none

package crfr_pkg;

    localparam logic [15:0] CRC_PRESET      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'h8408;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
    localparam logic [15:0] IDLE_MAX        = 16'hFFFF;
    localparam logic [7:0]  MIN_FRAME_LEN   = 8'd4;

    // Item kinds on the input channel
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_OK      = 2'd0,
        VERDICT_CRC_BAD = 2'd1,
        VERDICT_TIMEOUT = 2'd2,
        VERDICT_SHORT   = 2'd3
    } t_verdict;

    // Reflected CRC-16 update over one byte, eight shift steps unrolled
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/crc16_response_frame_receiver.sv */
// Channel   | Direction | Handshake                  | Payload
// input     | in        | i_in_valid / o_in_ready    | i_op, i_rx_byte
// result    | out       | o_out_valid / i_out_ready  | frame byte, index, end, verdict,
//           |           |                            | address, response code
// config    | in        | i_cfg_wr_en (no wait)      | i_cfg_wr_data (timeout_ticks)
// One item per cycle: all work for an item is done in the cycle it is accepted and its
// result lands in the output register; the 8-step CRC update is the longest path.
// A result is registered in the cycle after its item; ticks outside a frame produce no result.
// Input stalls only while the output register holds a result that is not taken.
// Reset is synchronous, active low, and needs no clearing pass.
// Frame receiver with length prefix, CRC-16 check and idle timeout; uses crfr_pkg.
`default_nettype none

module crc16_response_frame_receiver
    import crfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_frame_byte,
    output logic [7:0]       o_byte_index,
    output logic             o_frame_end,
    output logic [1:0]       o_verdict,
    output logic [7:0]       o_address,
    output logic [7:0]       o_response_code
);

    // Frame state
    logic [15:0] r_timeout_ticks;
    logic        r_in_frame, n_in_frame;
    logic [7:0]  r_frame_length, n_frame_length;
    logic [7:0]  r_byte_count, n_byte_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_low, n_crc_low;
    logic [15:0] r_idle, n_idle;
    logic [7:0]  r_addr, n_addr;
    logic [7:0]  r_code, n_code;

    // Output register
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [7:0]  r_out_index;
    logic        r_out_end;
    t_verdict    r_out_verdict;
    logic [7:0]  r_out_addr;
    logic [7:0]  r_out_code;

    // Result of the accepted item
    logic        res_valid;
    logic [7:0]  res_byte;
    logic [7:0]  res_index;
    logic        res_end;
    t_verdict    res_verdict;

    logic        take;
    logic        slot_free;
    logic [15:0] idle_inc;
    logic [8:0]  idx_p1;
    logic [8:0]  idx_p2;
    logic [8:0]  len9;
    logic [15:0] crc_in;

    // Accept while the output register is empty or being emptied
    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = slot_free;
    assign take       = i_in_valid && slot_free;

    assign idle_inc = (r_idle != IDLE_MAX) ? r_idle + 16'd1 : r_idle;
    assign idx_p1   = {1'b0, r_byte_count} + 9'd1;
    assign idx_p2   = {1'b0, r_byte_count} + 9'd2;
    assign len9     = {1'b0, r_frame_length};
    // CRC input: the preset on a length byte, the running value inside a frame
    assign crc_in   = r_in_frame ? r_crc : CRC_PRESET;

    // Next state and result for the accepted item
    always_comb begin
        n_in_frame     = r_in_frame;
        n_frame_length = r_frame_length;
        n_byte_count   = r_byte_count;
        n_crc          = r_crc;
        n_crc_low      = r_crc_low;
        n_idle         = r_idle;
        n_addr         = r_addr;
        n_code         = r_code;
        res_valid      = 1'b0;
        res_byte       = i_rx_byte;
        res_index      = r_byte_count;
        res_end        = 1'b0;
        res_verdict    = VERDICT_OK;
        if (take) begin
            if (i_op == OP_TICK) begin
                // Count idle ticks inside a frame, abort on reaching the limit
                if (r_in_frame) begin
                    n_idle = idle_inc;
                    if (idle_inc >= r_timeout_ticks) begin
                        n_in_frame  = 1'b0;
                        n_idle      = '0;
                        res_valid   = 1'b1;
                        res_byte    = 8'h00;
                        res_end     = 1'b1;
                        res_verdict = VERDICT_TIMEOUT;
                    end
                end
            end else begin
                n_idle    = '0;
                res_valid = 1'b1;
                if (!r_in_frame) begin
                    // Length byte opens a new frame
                    n_frame_length = i_rx_byte;
                    n_addr         = '0;
                    n_code         = '0;
                    n_crc_low      = '0;
                    n_crc          = (i_rx_byte >= 8'd2) ? crc_byte(crc_in, i_rx_byte)
                                                         : CRC_PRESET;
                    res_index      = '0;
                    if (i_rx_byte == 8'd0) begin
                        n_byte_count = '0;
                        res_end      = 1'b1;
                        res_verdict  = VERDICT_SHORT;
                    end else begin
                        n_in_frame   = 1'b1;
                        n_byte_count = 8'd1;
                    end
                end else begin
                    // Body byte: capture header fields, run CRC, check at the end
                    if (r_byte_count == 8'd1) begin
                        n_addr = i_rx_byte;
                    end
                    if (r_byte_count == 8'd2) begin
                        n_code = i_rx_byte;
                    end
                    if (idx_p2 <= len9) begin
                        n_crc = crc_byte(crc_in, i_rx_byte);
                    end
                    if (idx_p1 == len9) begin
                        n_crc_low = i_rx_byte;
                    end
                    if (r_byte_count >= r_frame_length) begin
                        n_in_frame = 1'b0;
                        res_end    = 1'b1;
                        if (r_frame_length < MIN_FRAME_LEN) begin
                            res_verdict = VERDICT_SHORT;
                        end else if (r_crc == {i_rx_byte, r_crc_low}) begin
                            res_verdict = VERDICT_OK;
                        end else begin
                            res_verdict = VERDICT_CRC_BAD;
                        end
                    end else begin
                        n_byte_count = idx_p1[7:0];
                    end
                end
            end
        end
    end

    // Control and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_RESET;
            r_in_frame      <= 1'b0;
            r_frame_length  <= '0;
            r_byte_count    <= '0;
            r_crc           <= CRC_PRESET;
            r_crc_low       <= '0;
            r_idle          <= '0;
            r_addr          <= '0;
            r_code          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout_ticks <= i_cfg_wr_data;
            end
            r_in_frame     <= n_in_frame;
            r_frame_length <= n_frame_length;
            r_byte_count   <= n_byte_count;
            r_crc          <= n_crc;
            r_crc_low      <= n_crc_low;
            r_idle         <= n_idle;
            r_addr         <= n_addr;
            r_code         <= n_code;
            if (slot_free) begin
                r_out_valid <= res_valid;
            end
        end
    end

    // Result payload: load when a new result is produced
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_byte    <= res_byte;
            r_out_index   <= res_index;
            r_out_end     <= res_end;
            r_out_verdict <= res_verdict;
            r_out_addr    <= n_addr;
            r_out_code    <= n_code;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_byte    = r_out_byte;
    assign o_byte_index    = r_out_index;
    assign o_frame_end     = r_out_end;
    assign o_verdict       = r_out_verdict;
    assign o_address       = r_out_addr;
    assign o_response_code = r_out_code;

endmodule

`default_nettype wire

/* rtl/crfr_checker.sv */
// Port-level checks for the frame receiver, bound to the top level.
// Depends on crfr_pkg and crc16_response_frame_receiver_defines.svh.
`default_nettype none
`include "crc16_response_frame_receiver_defines.svh"

module crfr_checker
    import crfr_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  o_frame_byte,
    input wire logic [7:0]  o_byte_index,
    input wire logic        o_frame_end,
    input wire logic [1:0]  o_verdict,
    input wire logic [7:0]  o_address,
    input wire logic [7:0]  o_response_code
);

    // Hold a stalled result
    `CRFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_frame_byte) && $stable(o_byte_index) && $stable(o_verdict),
        "stalled result changed")

    // Stall input only behind a full output register
    `CRFR_ASSERT_NOW(a_ready_full, i_clk, i_rst_n, !o_in_ready, o_out_valid,
        "input stalled with empty output register")

    // Mid-frame items carry no verdict
    `CRFR_ASSERT_NOW(a_mid_ok, i_clk, i_rst_n, o_out_valid && !o_frame_end,
        o_verdict == VERDICT_OK, "verdict set before frame end")

    // Timeout aborts end the frame with a zero byte past the length byte
    `CRFR_ASSERT_NOW(a_timeout_shape, i_clk, i_rst_n,
        o_out_valid && o_verdict == VERDICT_TIMEOUT,
        o_frame_end && o_frame_byte == 8'h00 && o_byte_index != 8'h00,
        "malformed timeout item")

    // A frame ending on its length byte is flagged short, with cleared header fields
    `CRFR_ASSERT_NOW(a_empty_frame, i_clk, i_rst_n,
        o_out_valid && o_frame_end && o_byte_index == 8'h00,
        o_verdict == VERDICT_SHORT && o_address == 8'h00 && o_response_code == 8'h00,
        "frame end at length byte not flagged short")

endmodule

bind crc16_response_frame_receiver crfr_checker u_crfr_checker (.*);

`default_nettype wire

/* bench/crc16_response_frame_receiver_tb.sv */
// Self-checking bench for the CRC-16 response frame receiver: directed frames, timeouts
// and random frame traffic with idle gaps on both channels, checked against a local model.
// Depends on crfr_pkg and the crc16_response_frame_receiver RTL.
module crc16_response_frame_receiver_tb;
    import crfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_rx_item;

    typedef struct packed {
        logic [7:0] fbyte;
        logic [7:0] index;
        logic       fend;
        t_verdict   verdict;
        logic [7:0] addr;
        logic [7:0] code;
    } t_frame_result;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_op = OP_BYTE;
    logic [7:0]  in_byte = '0;
    logic        out_ready = 1'b0;
    wire         o_in_ready;
    wire         o_out_valid;
    wire [7:0]   o_frame_byte;
    wire [7:0]   o_byte_index;
    wire         o_frame_end;
    wire [1:0]   o_verdict;
    wire [7:0]   o_address;
    wire [7:0]   o_response_code;

    t_rx_item      rx_items[$];
    t_frame_result frame_results[$];
    t_rx_item      cur_item;
    int            pushed_count = 0;
    int            accepted_count = 0;
    int            mismatches = 0;
    int            gap_left = 0;
    int            stall_left = 0;
    int            quiet_cycles = 0;
    bit            idle_on = 1'b1;

    // Receiver model state
    logic [15:0] timeout_cfg = TIMEOUT_RESET;
    logic        rx_active = 1'b0;
    logic [7:0]  len_byte = '0;
    logic [7:0]  next_index = '0;
    logic [15:0] crc_run = CRC_PRESET;
    logic [7:0]  crc_lo = '0;
    logic [15:0] idle_ticks = '0;
    logic [7:0]  addr_cap = '0;
    logic [7:0]  code_cap = '0;

    crc16_response_frame_receiver uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (in_op),
        .i_rx_byte       (in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_frame_byte    (o_frame_byte),
        .o_byte_index    (o_byte_index),
        .o_frame_end     (o_frame_end),
        .o_verdict       (o_verdict),
        .o_address       (o_address),
        .o_response_code (o_response_code)
    );

    always #4 clk = ~clk;

    // Reflected CRC-16, one input bit per step, LSB first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ data[i];
            c = {1'b0, c[15:1]};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Advance the receiver model by one item and queue the response it causes
    function automatic void predict_response(input logic op, input logic [7:0] b);
        t_frame_result r;
        logic [15:0]   lim;
        int            idx;
        int            len;
        t_verdict      v;
        lim = (timeout_cfg == 16'd0) ? 16'd1 : timeout_cfg;
        if (op == OP_TICK) begin
            if (rx_active) begin
                if (idle_ticks != IDLE_MAX) begin
                    idle_ticks++;
                end
                if (idle_ticks >= lim) begin
                    rx_active = 1'b0;
                    idle_ticks = '0;
                    r = '{fbyte: 8'h00, index: next_index, fend: 1'b1,
                          verdict: VERDICT_TIMEOUT, addr: addr_cap, code: code_cap};
                    frame_results.push_back(r);
                end
            end
            return;
        end
        idle_ticks = '0;
        if (!rx_active) begin
            len_byte = b;
            addr_cap = '0;
            code_cap = '0;
            crc_lo = '0;
            crc_run = CRC_PRESET;
            if (b >= 8'd2) begin
                crc_run = crc16_update(crc_run, b);
            end
            if (b == 8'd0) begin
                next_index = '0;
                r = '{fbyte: b, index: 8'd0, fend: 1'b1, verdict: VERDICT_SHORT,
                      addr: addr_cap, code: code_cap};
            end else begin
                rx_active = 1'b1;
                next_index = 8'd1;
                r = '{fbyte: b, index: 8'd0, fend: 1'b0, verdict: VERDICT_OK,
                      addr: addr_cap, code: code_cap};
            end
            frame_results.push_back(r);
            return;
        end
        idx = next_index;
        len = len_byte;
        if (idx == 1) begin
            addr_cap = b;
        end
        if (idx == 2) begin
            code_cap = b;
        end
        if (idx + 2 <= len) begin
            crc_run = crc16_update(crc_run, b);
        end
        if (idx + 1 == len) begin
            crc_lo = b;
        end
        if (idx >= len) begin
            if (len < MIN_FRAME_LEN) begin
                v = VERDICT_SHORT;
            end else if (crc_run == {b, crc_lo}) begin
                v = VERDICT_OK;
            end else begin
                v = VERDICT_CRC_BAD;
            end
            rx_active = 1'b0;
            r = '{fbyte: b, index: next_index, fend: 1'b1, verdict: v,
                  addr: addr_cap, code: code_cap};
        end else begin
            next_index = next_index + 8'd1;
            r = '{fbyte: b, index: idx[7:0], fend: 1'b0, verdict: VERDICT_OK,
                  addr: addr_cap, code: code_cap};
        end
        frame_results.push_back(r);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Input driver: present queued items, predict on acceptance
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_response(cur_item.op, cur_item.data);
                accepted_count++;
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (rx_items.size() != 0) begin
                    cur_item = rx_items.pop_front();
                    in_op <= cur_item.op;
                    in_byte <= cur_item.data;
                    in_valid <= 1'b1;
                    gap_left = idle_on ? pick_gap() : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted result with the oldest prediction
    always @(posedge clk) begin
        t_frame_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (frame_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual byte %0d index %0d",
                             $time, o_frame_byte, o_byte_index);
                end else begin
                    want = frame_results.pop_front();
                    check_field("frame_byte", want.fbyte, o_frame_byte);
                    check_field("byte_index", want.index, o_byte_index);
                    check_field("frame_end", want.fend, o_frame_end);
                    check_field("verdict", int'(want.verdict), o_verdict);
                    check_field("address", want.addr, o_address);
                    check_field("response_code", want.code, o_response_code);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rx_items.push_back('{op: OP_BYTE, data: b});
        pushed_count++;
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++) begin
            rx_items.push_back('{op: OP_TICK, data: 8'($urandom_range(0, 255))});
            pushed_count++;
        end
    endtask

    // Queue one frame, with a valid CRC when len is at least MIN_FRAME_LEN; optionally flip one bit in byte flip_at
    task automatic queue_frame(input int len, input int flip_at, input int tick_cap);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        fb.push_back(len[7:0]);
        for (int i = 1; i <= len; i++) begin
            fb.push_back(8'($urandom_range(0, 255)));
        end
        if (len >= MIN_FRAME_LEN) begin
            crc = CRC_PRESET;
            for (int i = 0; i <= len - 2; i++) begin
                crc = crc16_update(crc, fb[i]);
            end
            fb[len - 1] = crc[7:0];
            fb[len] = crc[15:8];
        end
        if (flip_at >= 0) begin
            fb[flip_at] = fb[flip_at] ^ (8'h01 << $urandom_range(0, 7));
        end
        foreach (fb[i]) begin
            if (i > 0 && tick_cap > 0 && $urandom_range(0, 99) < 15) begin
                push_ticks($urandom_range(1, tick_cap));
            end
            push_byte(fb[i]);
        end
    endtask

    // Hold until every item is taken and every result has arrived
    task automatic settle();
        @(posedge clk);
        while (accepted_count != pushed_count || frame_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        timeout_cfg = v;
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(0, 10);
        end else if (r < 95) begin
            return $urandom_range(11, 40);
        end
        return $urandom_range(41, 80);
    endfunction

    initial begin
        logic [15:0] tmo;
        int          lim;
        int          cap;
        int          target;
        int          r;
        int          len;
        bit          resync_ok;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: stray tick, short frames, good and bad CRC at the reset timeout
        push_ticks(1);
        push_byte(8'h00);
        push_byte(8'h01); push_byte(8'hFF);
        push_byte(8'h02); push_byte(8'h00); push_byte(8'hFF);
        push_byte(8'h03); push_byte(8'hFF); push_byte(8'h00); push_byte(8'hFF);
        queue_frame(4, -1, 0);
        queue_frame(4, 4, 0);
        // Idle ticks well inside the reset timeout keep the frame open
        push_byte(8'h06); push_byte(8'hA5); push_byte(8'h5A);
        push_ticks(10);
        push_byte(8'h3C);
        settle();

        // Idle just below the limit, then a full timeout
        write_timeout(16'd6);
        push_ticks(5);
        push_byte(8'h7E);
        push_ticks(6);
        push_ticks(2);
        settle();

        // Timeout of one: the first idle tick aborts
        write_timeout(16'd1);
        push_byte(8'h05); push_byte(8'h11);
        push_ticks(2);
        settle();

        // Timeout of zero behaves as one
        write_timeout(16'd0);
        push_byte(8'h04); push_byte(8'h22); push_byte(8'h33);
        push_ticks(1);
        settle();

        // Largest timeout: idle ticks do not abort, the frame ends normally
        write_timeout(16'hFFFF);
        idle_on = 1'b0;
        push_byte(8'h02); push_byte(8'h44);
        push_ticks(8);
        push_byte(8'h55);
        settle();
        idle_on = 1'b1;

        // Random traffic under several timeout settings
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: tmo = 16'd3;
                1: tmo = 16'd1;
                2: tmo = 16'($urandom_range(2, 40));
                3: tmo = 16'd7;
                4: tmo = 16'hFFFF;
                default: tmo = 16'($urandom_range(1, 12));
            endcase
            write_timeout(tmo);
            lim = (tmo == 16'd0) ? 1 : int'(tmo);
            cap = (lim - 1 < 3) ? lim - 1 : 3;
            resync_ok = (lim <= 64);
            idle_on = (p != 2);
            target = pushed_count + 15;
            while (pushed_count < target) begin
                r = $urandom_range(0, 99);
                len = pick_len();
                if (!resync_ok || r < 75) begin
                    queue_frame(len, -1, cap);
                end else if (r < 90) begin
                    // Broken frame, then enough ticks to drop whatever is open
                    queue_frame(len, $urandom_range(0, len), cap);
                    push_ticks(lim);
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        rx_items.push_back('{op: 1'($urandom_range(0, 1)),
                                             data: 8'($urandom_range(0, 255))});
                        pushed_count++;
                    end
                    push_ticks(lim);
                end
            end
            if (p == 0) begin
                queue_frame(255, -1, 0);
            end
            settle();
        end
        idle_on = 1'b1;

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/crfr_pkg.sv
rtl/crc16_response_frame_receiver.sv
rtl/crfr_checker.sv
bench/crc16_response_frame_receiver_tb.sv
